// ===== design/prrs_pkg.sv =====
// Shared types, constants and codes of the priority round-robin scheduler.
`default_nettype none
package prrs_pkg;

	localparam int NUM_PRIO    = 8;
	localparam int MAX_THREADS = 64;
	localparam int TID_W       = 6;
	localparam int PRIO_W      = 3;
	localparam int CNT_W       = $clog2(MAX_THREADS + 1);

	typedef enum logic [1:0] {
		CMD_ADD  = 2'd0,
		CMD_WAIT = 2'd1,
		CMD_WAKE = 2'd2,
		CMD_SEL  = 2'd3
	} cmd_t;

	localparam logic [1:0] STAT_NEW  = 2'd0;
	localparam logic [1:0] STAT_RUN  = 2'd1;
	localparam logic [1:0] STAT_WAIT = 2'd2;

	// one thread entry of the thread memory
	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [1:0]        status;
		logic              linked;
		logic [TID_W-1:0]  nxt;
		logic [TID_W-1:0]  prv;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

	typedef struct packed {
		logic             re;
		logic             we;
		logic [TID_W-1:0] addr;
		ent_t             wdata;
	} tm_req_t;

	typedef enum logic [1:0] {
		K_PREV,
		K_NEXT,
		K_LINK,
		K_LINK_ONLY
	} mod_t;

	typedef struct packed {
		logic             vld;
		logic [TID_W-1:0] addr;
		mod_t             kind;
		logic [TID_W-1:0] val;
	} sec_op_t;

	typedef struct packed {
		logic              en;
		logic [PRIO_W-1:0] idx;
		logic              head_we;
		logic [TID_W-1:0]  head_val;
		logic              tail_we;
		logic [TID_W-1:0]  tail_val;
		logic              cnt_inc;
		logic              cnt_dec;
		logic              cur_set;
		logic              cur_clr;
		logic [TID_W-1:0]  cur_val;
	} prio_upd_t;

	typedef struct packed {
		logic [TID_W-1:0] head;
		logic [TID_W-1:0] tail;
		logic [CNT_W-1:0] cnt;
		logic             cur_vld;
		logic [TID_W-1:0] cur_id;
		logic             len_pos;
		logic             len_multi;
	} prio_view_t;

	typedef struct packed {
		logic              found;
		logic [PRIO_W-1:0] pidx;
	} scan_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CHK,
		S_SRD,
		S_SWR,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== design/prrs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module prrs_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== design/prrs_tmem.sv =====
// Thread memory: entry RAM plus per-entry valid bits that read unwritten entries as new.
`default_nettype none
module prrs_tmem
	import prrs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire tm_req_t req,
	output ent_t         rdata
);

	logic [ENT_W-1:0]  ram_q;
	logic              vld_q [MAX_THREADS];
	logic              rvld_q;
	ent_t              raw;

	prrs_ram #(
		.DEPTH (MAX_THREADS),
		.WIDTH (ENT_W)
	) u_ram (
		.clk   (clk),
		.we    (req.we),
		.waddr (req.addr),
		.wdata (req.wdata),
		.re    (req.re),
		.raddr (req.addr),
		.rdata (ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_THREADS; i++) begin
				vld_q[i] <= 1'b0;
			end
			rvld_q <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.re) begin
				rvld_q <= vld_q[req.addr];
			end
		end
	end

	// unwritten entry: status new, not linked
	always_comb begin
		raw   = ent_t'(ram_q);
		rdata = raw;
		if (!rvld_q) begin
			rdata.status = STAT_NEW;
			rdata.linked = 1'b0;
		end
	end

	a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.re && req.we))
		else $error("thread memory read and written in one cycle");

endmodule
`default_nettype wire

// ===== design/prrs_prio.sv =====
// Per-priority list heads, tails, counts and current marks, with the priority scan.
`default_nettype none
module prrs_prio
	import prrs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire prio_upd_t         upd,
	input  wire logic [PRIO_W-1:0] q_idx,
	input  wire logic [TID_W-1:0]  q_tid,
	output prio_view_t             view,
	output scan_t                  scan,
	output logic                   tid_is_cur
);

	logic [TID_W-1:0] head_q   [NUM_PRIO];
	logic [TID_W-1:0] tail_q   [NUM_PRIO];
	logic [CNT_W-1:0] cnt_q    [NUM_PRIO];
	logic             cur_vld_q[NUM_PRIO];
	logic [TID_W-1:0] cur_id_q [NUM_PRIO];
	logic [CNT_W-1:0] curbit;

	always_comb begin
		view.head      = head_q[q_idx];
		view.tail      = tail_q[q_idx];
		view.cnt       = cnt_q[q_idx];
		view.cur_vld   = cur_vld_q[q_idx];
		view.cur_id    = cur_id_q[q_idx];
		curbit         = CNT_W'(cur_vld_q[q_idx]);
		view.len_pos   = cnt_q[q_idx] > curbit;
		view.len_multi = cnt_q[q_idx] > (curbit + CNT_W'(1));
	end

	// lowest priority number holding a thread wins
	always_comb begin
		scan.found = 1'b0;
		scan.pidx  = '0;
		for (int p = NUM_PRIO - 1; p >= 0; p--) begin
			if (cur_vld_q[p] || (cnt_q[p] != '0)) begin
				scan.found = 1'b1;
				scan.pidx  = PRIO_W'(p);
			end
		end
	end

	always_comb begin
		tid_is_cur = 1'b0;
		for (int p = 0; p < NUM_PRIO; p++) begin
			if (cur_vld_q[p] && (cur_id_q[p] == q_tid)) begin
				tid_is_cur = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en) begin
			if (upd.head_we) begin
				head_q[upd.idx] <= upd.head_val;
			end
			if (upd.tail_we) begin
				tail_q[upd.idx] <= upd.tail_val;
			end
			if (upd.cur_set) begin
				cur_id_q[upd.idx] <= upd.cur_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PRIO; p++) begin
				cnt_q[p]     <= '0;
				cur_vld_q[p] <= 1'b0;
			end
		end else if (upd.en) begin
			if (upd.cnt_inc) begin
				cnt_q[upd.idx] <= cnt_q[upd.idx] + CNT_W'(1);
			end else if (upd.cnt_dec) begin
				cnt_q[upd.idx] <= cnt_q[upd.idx] - CNT_W'(1);
			end
			if (upd.cur_set) begin
				cur_vld_q[upd.idx] <= 1'b1;
			end else if (upd.cur_clr) begin
				cur_vld_q[upd.idx] <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/priority_round_robin_scheduler.sv =====
// Top level: request sequencer over the thread memory, per-priority file and result register.
// Sequence: an accepted request passes through states S_RD and S_CHK to S_DONE; each of
// the one or two neighbouring list entries that are rewritten adds an S_SRD, S_SWR pass.
// A new request is taken only in S_IDLE, after the previous one has finished its passes
// through the single-port-pair thread memory (registered read data), and S_DONE waits
// while the previous result is still held, untaken, in the result register.
// Reset: arst_n clears counts, current marks, running thread and entry valid bits at once;
// the block is idle and ready to accept requests as soon as reset is released.
`default_nettype none
module priority_round_robin_scheduler
	import prrs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [5:0] thread_id, [8:6] priority_req, rest zero
	input  wire logic [1:0]  s_tuser,  // [1:0] cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // [5:0] chosen_thread, rest zero
	output logic [2:0]       m_tuser   // [0] is_idle, [1] first_run, [2] error
);

	state_t            state_q, state_n;
	cmd_t              cmd_q;
	logic [TID_W-1:0]  tid_q;
	logic [PRIO_W-1:0] preq_q;
	logic              run_vld_q;
	logic [TID_W-1:0]  run_id_q;
	sec_op_t           op_q [2];
	sec_op_t           op_n [2];
	logic              sec_idx_q;

	logic [TID_W-1:0]  res_chosen_q, res_chosen_n;
	logic              res_idle_q, res_idle_n;
	logic              res_first_q, res_first_n;
	logic              res_err_q, res_err_n;
	logic              run_set, run_clr;
	logic [TID_W-1:0]  run_val;

	logic              m_tvalid_q;
	logic [TID_W-1:0]  m_chosen_q;
	logic              m_idle_q, m_first_q, m_err_q;
	logic              out_free;

	tm_req_t           tm_req;
	ent_t              rd;
	ent_t              wr;
	prio_upd_t         pupd;
	prio_view_t        view;
	scan_t             scan;
	logic              tid_is_cur;
	logic [PRIO_W-1:0] q_idx;
	sec_op_t           cur_op;

	// Patch one field group of a neighbouring entry, keeping the rest as read.
	function automatic ent_t apply_mod(input ent_t e, input mod_t k, input logic [TID_W-1:0] v);
		ent_t r;
		r = e;
		unique case (k)
			K_PREV:      r.prv = v;
			K_NEXT:      r.nxt = v;
			K_LINK: begin
				r.linked = 1'b1;
				r.prv    = v;
			end
			K_LINK_ONLY: r.linked = 1'b1;
		endcase
		return r;
	endfunction

	prrs_tmem u_tmem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tm_req),
		.rdata  (rd)
	);

	prrs_prio u_prio (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (pupd),
		.q_idx      (q_idx),
		.q_tid      (tid_q),
		.view       (view),
		.scan       (scan),
		.tid_is_cur (tid_is_cur)
	);

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign cur_op   = op_q[sec_idx_q];

	// Priority of interest: the request's for add, the scan winner for select,
	// and the thread's stored priority for wait and wake.
	always_comb begin
		unique case (cmd_q)
			CMD_ADD:  q_idx = preq_q;
			CMD_SEL:  q_idx = scan.pidx;
			CMD_WAIT: q_idx = rd.prio;
			CMD_WAKE: q_idx = rd.prio;
		endcase
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: if (s_tvalid) state_n = S_RD;
			S_RD:   state_n = S_CHK;
			S_CHK:  state_n = op_n[0].vld ? S_SRD : S_DONE;
			S_SRD:  state_n = S_SWR;
			S_SWR:  state_n = (!sec_idx_q && op_q[1].vld) ? S_SRD : S_DONE;
			S_DONE: if (out_free) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// memory requests, list updates and result per state
	always_comb begin
		tm_req       = '0;
		pupd         = '0;
		pupd.idx     = q_idx;
		op_n[0]      = '0;
		op_n[1]      = '0;
		res_chosen_n = '0;
		res_idle_n   = 1'b0;
		res_first_n  = 1'b0;
		res_err_n    = 1'b0;
		run_set      = 1'b0;
		run_clr      = 1'b0;
		run_val      = '0;
		wr           = rd;

		unique case (state_q)
			S_RD: begin
				// fetch the primary thread entry of the request
				tm_req.re = 1'b1;
				unique case (cmd_q)
					CMD_ADD:  tm_req.addr = tid_q;
					CMD_WAKE: tm_req.addr = tid_q;
					CMD_WAIT: tm_req.addr = run_id_q;
					CMD_SEL:  tm_req.addr = view.len_pos ? view.head : view.cur_id;
				endcase
			end
			S_CHK: begin
				tm_req.addr = tid_q;
				unique case (cmd_q)
					CMD_ADD: begin
						res_chosen_n = tid_q;
						if ((int'(tid_q) >= MAX_THREADS) || (int'(preq_q) >= NUM_PRIO) ||
							rd.linked || tid_is_cur) begin
							res_err_n = 1'b1;
						end else begin
							// link at head; old head points back to the new one
							wr.prio      = preq_q;
							wr.linked    = 1'b1;
							wr.nxt       = view.head;
							tm_req.we    = 1'b1;
							tm_req.wdata = wr;
							pupd.en       = 1'b1;
							pupd.cnt_inc  = 1'b1;
							pupd.head_we  = 1'b1;
							pupd.head_val = tid_q;
							if (!view.len_pos) begin
								pupd.tail_we  = 1'b1;
								pupd.tail_val = tid_q;
							end else begin
								op_n[0] = '{vld: 1'b1, addr: view.head, kind: K_PREV, val: tid_q};
							end
						end
					end
					CMD_WAIT: begin
						tm_req.addr = run_id_q;
						if (!run_vld_q || (int'(rd.prio) >= NUM_PRIO) || (view.cnt == '0)) begin
							res_err_n = 1'b1;
						end else begin
							res_chosen_n = run_id_q;
							wr.status    = STAT_WAIT;
							wr.linked    = 1'b0;
							tm_req.we    = 1'b1;
							tm_req.wdata = wr;
							pupd.en      = 1'b1;
							pupd.cnt_dec = 1'b1;
							run_clr      = 1'b1;
							if (view.cur_vld && (view.cur_id == run_id_q)) begin
								pupd.cur_clr = 1'b1;
							end
							if (rd.linked) begin
								// unlink: move an end pointer, or splice the neighbours
								priority if ((view.head == run_id_q) && (view.tail != run_id_q)) begin
									pupd.head_we  = 1'b1;
									pupd.head_val = rd.nxt;
								end else if ((view.tail == run_id_q) && (view.head != run_id_q)) begin
									pupd.tail_we  = 1'b1;
									pupd.tail_val = rd.prv;
								end else if ((view.head != run_id_q) && (view.tail != run_id_q)) begin
									op_n[0] = '{vld: 1'b1, addr: rd.prv, kind: K_NEXT, val: rd.nxt};
									op_n[1] = '{vld: 1'b1, addr: rd.nxt, kind: K_PREV, val: rd.prv};
								end
							end
						end
					end
					CMD_WAKE: begin
						res_chosen_n = tid_q;
						if ((int'(tid_q) >= MAX_THREADS) || (rd.status != STAT_WAIT) ||
							rd.linked || tid_is_cur || (int'(rd.prio) >= NUM_PRIO)) begin
							res_err_n = 1'b1;
						end else begin
							// link at tail
							wr.status    = STAT_RUN;
							wr.linked    = 1'b1;
							wr.prv       = view.tail;
							tm_req.we    = 1'b1;
							tm_req.wdata = wr;
							pupd.en       = 1'b1;
							pupd.cnt_inc  = 1'b1;
							pupd.tail_we  = 1'b1;
							pupd.tail_val = tid_q;
							if (!view.len_pos) begin
								pupd.head_we  = 1'b1;
								pupd.head_val = tid_q;
							end else begin
								op_n[0] = '{vld: 1'b1, addr: view.tail, kind: K_NEXT, val: tid_q};
							end
						end
					end
					CMD_SEL: begin
						if (!scan.found) begin
							res_idle_n = 1'b1;
							run_clr    = 1'b1;
						end else begin
							tm_req.addr = view.len_pos ? view.head : view.cur_id;
							res_chosen_n = tm_req.addr;
							run_set      = 1'b1;
							run_val      = tm_req.addr;
							if (rd.status == STAT_NEW) begin
								res_first_n = 1'b1;
								wr.status   = STAT_RUN;
							end
							tm_req.we = 1'b1;
							if (view.len_pos) begin
								// pop the head, make it current, re-queue the old current
								wr.linked     = 1'b0;
								pupd.en       = 1'b1;
								pupd.cur_set  = 1'b1;
								pupd.cur_val  = view.head;
								if (view.len_multi) begin
									pupd.head_we  = 1'b1;
									pupd.head_val = rd.nxt;
								end
								if (view.cur_vld) begin
									if (!view.len_multi) begin
										pupd.head_we  = 1'b1;
										pupd.head_val = view.cur_id;
										pupd.tail_we  = 1'b1;
										pupd.tail_val = view.cur_id;
										op_n[0] = '{vld: 1'b1, addr: view.cur_id,
											kind: K_LINK_ONLY, val: '0};
									end else begin
										pupd.tail_we  = 1'b1;
										pupd.tail_val = view.cur_id;
										op_n[0] = '{vld: 1'b1, addr: view.tail,
											kind: K_NEXT, val: view.cur_id};
										op_n[1] = '{vld: 1'b1, addr: view.cur_id,
											kind: K_LINK, val: view.tail};
									end
								end
							end
							tm_req.wdata = wr;
						end
					end
				endcase
			end
			S_SRD: begin
				tm_req.re   = 1'b1;
				tm_req.addr = cur_op.addr;
			end
			S_SWR: begin
				tm_req.we    = 1'b1;
				tm_req.addr  = cur_op.addr;
				tm_req.wdata = apply_mod(rd, cur_op.kind, cur_op.val);
			end
			default: begin
			end
		endcase
	end

	// request capture and sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cmd_q     <= CMD_ADD;
			run_vld_q <= 1'b0;
			sec_idx_q <= 1'b0;
			op_q[0]   <= '0;
			op_q[1]   <= '0;
		end else begin
			state_q <= state_n;
			if (s_tvalid && s_tready) begin
				cmd_q <= cmd_t'(s_tuser[1:0]);
			end
			if (state_q == S_CHK) begin
				op_q[0]   <= op_n[0];
				op_q[1]   <= op_n[1];
				sec_idx_q <= 1'b0;
				if (run_set) begin
					run_vld_q <= 1'b1;
				end else if (run_clr) begin
					run_vld_q <= 1'b0;
				end
			end
			if (state_q == S_SWR) begin
				sec_idx_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tid_q  <= s_tdata[5:0];
			preq_q <= s_tdata[8:6];
		end
		if (state_q == S_CHK) begin
			res_chosen_q <= res_chosen_n;
			res_idle_q   <= res_idle_n;
			res_first_q  <= res_first_n;
			res_err_q    <= res_err_n;
			if (run_set) begin
				run_id_q <= run_val;
			end
		end
	end

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			m_chosen_q <= res_chosen_q;
			m_idle_q   <= res_idle_q;
			m_first_q  <= res_first_q;
			m_err_q    <= res_err_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, m_chosen_q};
	assign m_tuser  = {m_err_q, m_first_q, m_idle_q};

	a_err_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK && res_err_n) |-> (!tm_req.we && !pupd.en && !op_n[0].vld))
		else $error("rejected request modified state");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the completion step");

	a_idle_chosen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_idle_q) |-> (m_chosen_q == '0 && !m_err_q && !m_first_q))
		else $error("idle result carries a thread");

endmodule
`default_nettype wire
